// File: rtl/heartbeat_supervisor_macros.svh
// assertion macros for the heartbeat supervisor
// used by the top level; expects clk and rst in scope
`ifndef HEARTBEAT_SUPERVISOR_MACROS_SVH
`define HEARTBEAT_SUPERVISOR_MACROS_SVH

// same-cycle implication
`define HBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hbs_pkg.sv
// types and constants of the heartbeat supervisor
// shared by hbs_eval and heartbeat_supervisor; no dependencies
package hbs_pkg;

  localparam logic [2:0] ST_READY   = 3'd0;
  localparam logic [2:0] ST_MISSING = 3'd1;
  localparam logic [2:0] ST_LATENCY = 3'd2;
  localparam logic [2:0] ST_FAILURE = 3'd3;
  localparam logic [2:0] ST_BOARD   = 3'd4;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_ALIVE = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  localparam logic [7:0] CFG_BOOT_GRACE   = 8'd0;
  localparam logic [7:0] CFG_ALIVE_PERIOD = 8'd1;
  localparam logic [7:0] CFG_TOLERANCE    = 8'd2;
  localparam logic [7:0] CFG_WINDOW_SIZE  = 8'd3;

  localparam logic [31:0] BOOT_GRACE_RST   = 32'd5000;
  localparam logic [15:0] ALIVE_PERIOD_RST = 16'd100;
  localparam logic [15:0] TOLERANCE_RST    = 16'd20;
  localparam logic [7:0]  WINDOW_SIZE_RST  = 8'd4;

  // missing limit is four alive intervals
  localparam int MISSING_SHIFT = 2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  frame_kind;
    logic        supervisor_failed;
    logic [7:0]  board1_error;
    logic [7:0]  board2_error;
  } evt_t;

  typedef struct packed {
    logic [2:0] status_out;
    logic       shutdown_now;
  } res_t;

  typedef struct packed {
    logic [31:0] boot_grace_ms;
    logic [15:0] alive_period_ms;
    logic [15:0] slack_ms;
    logic [7:0]  window_size;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic [31:0] last_alive_time;
    logic [7:0]  valid_window;
  } state_t;

endpackage

// File: rtl/hbs_eval.sv
// single-item evaluation of the heartbeat checks
// depends on hbs_pkg
module hbs_eval (
  input  hbs_pkg::cfg_t   cfg,
  input  hbs_pkg::state_t cur,
  input  hbs_pkg::evt_t   item,
  output hbs_pkg::state_t nxt,
  output hbs_pkg::res_t   res
);
  import hbs_pkg::*;

  logic        alive;
  logic [31:0] elapsed;
  logic [16:0] interval;
  logic [18:0] missing_limit;
  logic        booted;
  logic        missing;
  logic        on_time;
  logic [8:0]  win_inc;
  logic [7:0]  win_next;
  logic        shut;

  assign alive         = (item.frame_kind == KIND_ALIVE);
  assign elapsed       = item.now_ms - cur.last_alive_time;
  assign interval      = {1'b0, cfg.alive_period_ms} + {1'b0, cfg.slack_ms};
  assign missing_limit = {2'b00, interval} << MISSING_SHIFT;
  assign booted        = item.now_ms > cfg.boot_grace_ms;
  assign missing       = booted && (elapsed > {13'd0, missing_limit});
  assign on_time       = elapsed < {15'd0, interval};
  assign win_inc       = {1'b0, cur.valid_window} + 9'd1;

  always_comb begin
    if (on_time) begin
      win_next = (win_inc < {1'b0, cfg.window_size}) ? win_inc[7:0] : cfg.window_size;
    end else begin
      win_next = (cur.valid_window != 8'd0) ? cur.valid_window - 8'd1 : 8'd0;
    end
  end

  always_comb begin
    nxt  = cur;
    shut = 1'b0;
    if (alive) begin
      nxt.last_alive_time = item.now_ms;
    end
    if (cur.status_code == ST_READY) begin
      if (missing) begin
        nxt.status_code = ST_MISSING;
        shut = 1'b1;
      end else if (alive) begin
        nxt.valid_window = win_next;
        if (win_next == 8'd0) begin
          nxt.status_code = ST_LATENCY;
          shut = 1'b1;
        end else if (item.supervisor_failed) begin
          nxt.status_code = ST_FAILURE;
          shut = 1'b1;
        end
      end
      if ((item.board1_error != 8'd0) || (item.board2_error != 8'd0)) begin
        nxt.status_code = ST_BOARD;
        shut = 1'b1;
      end
    end else if (item.frame_kind == KIND_RESET) begin
      nxt.status_code = ST_READY;
    end
    res.status_out   = nxt.status_code;
    res.shutdown_now = shut;
  end

endmodule

// File: rtl/heartbeat_supervisor.sv
// heartbeat supervisor top level: input register, evaluation, result register
// depends on hbs_pkg, hbs_eval and heartbeat_supervisor_macros.svh
//
// channel | signals                          | direction
// evt     | evt_valid, evt_stall, evt_word   | in, stall out
// res     | res_valid, res_stall, res_word   | out, stall in
// cfg     | cfg_valid, cfg_ready, cfg_index, | in, ready out
//         | cfg_data                         |
//
// one word per cycle unless res_stall; res_valid follows evt accept via the
// input and result registers; rate is set by the single register update of
// status and alive state; synchronous rst clears status, alive time, window
// and restores config; evt_stall rises only when both registers are full
// and res_stall is high; cfg is always ready, unknown indexes are dropped
`include "heartbeat_supervisor_macros.svh"

module heartbeat_supervisor (
  input  logic            clk,
  input  logic            rst,
  input  logic            evt_valid,
  output logic            evt_stall,
  input  hbs_pkg::evt_t   evt_word,
  output logic            res_valid,
  input  logic            res_stall,
  output hbs_pkg::res_t   res_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import hbs_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  res_t   res_calc;
  logic   s1_valid;
  evt_t   s1_word;
  logic   adv;
  logic   eval_go;
  logic   reset_go;
  logic   out_shut;
  logic   out_ready;
  logic   is_down;

  assign adv       = !res_valid || !res_stall;
  assign evt_stall = s1_valid && !adv;
  assign cfg_ready = 1'b1;

  hbs_eval u_eval (
    .cfg  (cfg),
    .cur  (state),
    .item (s1_word),
    .nxt  (state_next),
    .res  (res_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_grace_ms   <= BOOT_GRACE_RST;
      cfg.alive_period_ms <= ALIVE_PERIOD_RST;
      cfg.slack_ms        <= TOLERANCE_RST;
      cfg.window_size     <= WINDOW_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOOT_GRACE:   cfg.boot_grace_ms   <= cfg_data;
        CFG_ALIVE_PERIOD: cfg.alive_period_ms <= cfg_data[15:0];
        CFG_TOLERANCE:    cfg.slack_ms        <= cfg_data[15:0];
        CFG_WINDOW_SIZE:  cfg.window_size     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!evt_stall) begin
      s1_valid <= evt_valid;
    end
    if (evt_valid && !evt_stall) begin
      s1_word <= evt_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      state     <= '0;
    end else if (adv) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        state <= state_next;
      end
    end
    if (adv && s1_valid) begin
      res_word <= res_calc;
    end
  end

  assign eval_go   = adv && s1_valid;
  assign reset_go  = eval_go && (s1_word.frame_kind == KIND_RESET);
  assign out_shut  = res_valid && res_word.shutdown_now;
  assign out_ready = (res_word.status_out == ST_READY);
  assign is_down   = (state.status_code != ST_READY);

  // a shutdown always leaves a non-ready status
  `HBS_ASSERT_NOW(a_shut_status, out_shut, !out_ready, "shutdown with ready status")

  // a shut-down block stays down unless a reset command is processed
  `HBS_ASSERT_NEXT(a_latched_down, is_down && !reset_go, is_down, "left shutdown without reset")

  // an evaluated word always shows up as a result
  `HBS_ASSERT_NEXT(a_res_loaded, eval_go, res_valid, "evaluated word lost")

endmodule
